@@ src/rhc_pkg.sv @@
package rhc_pkg;

  localparam logic [15:0] ONE_Q15  = 16'd32768;
  localparam logic [15:0] HALF_Q15 = 16'd16384;
  localparam logic [15:0] HUE_60   = 16'd7680;
  localparam logic [15:0] HUE_120  = 16'd15360;
  localparam logic [15:0] HUE_180  = 16'd23040;
  localparam logic [15:0] HUE_240  = 16'd30720;
  localparam logic [15:0] HUE_360  = 16'd46080;

  // floor(y / 45) = (y * REC45) >> 20 for y < 2^14
  localparam logic [14:0] REC45    = 15'd23302;
  // floor(y / 15) = (y * REC15) >> 23 for y < 2^19
  localparam logic [19:0] REC15    = 20'd559241;

  typedef enum logic [2:0] {
    OP_TO_HLS    = 3'd0,
    OP_FROM_HLS  = 3'd1,
    OP_SET_HUE   = 3'd2,
    OP_SET_SAT   = 3'd3,
    OP_SET_LUM   = 3'd4,
    OP_SCALE_HUE = 3'd5,
    OP_SCALE_SAT = 3'd6,
    OP_SCALE_LUM = 3'd7
  } rhc_op_t;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } rhc_base_t;

  typedef enum logic [1:0] {
    PIECE_RISE = 2'd0,
    PIECE_HIGH = 2'd1,
    PIECE_FALL = 2'd2,
    PIECE_LOW  = 2'd3
  } rhc_piece_kind_t;

  typedef struct packed {
    rhc_op_t     op;
    logic [15:0] chan_a_in;
    logic [15:0] chan_b_in;
    logic [15:0] chan_c_in;
    logic [15:0] alpha_in;
    logic [15:0] amount;
  } rhc_in_t;

  typedef struct packed {
    logic [15:0] chan_a_out;
    logic [15:0] chan_b_out;
    logic [15:0] chan_c_out;
    logic [15:0] alpha_out;
  } rhc_out_t;

  typedef struct packed {
    rhc_op_t     op;
    logic [15:0] alpha;
    logic [15:0] amt;
    logic [15:0] l;
    logic [15:0] hin;
    logic [15:0] sin;
    logic        zero;
    logic        neg;
    rhc_base_t   base;
  } rhc_side_t;

  typedef struct packed {
    rhc_op_t     op;
    logic [15:0] alpha;
    logic [15:0] amt;
    logic [15:0] h;
    logic [15:0] l;
    logic [15:0] s;
  } rhc_hls_t;

  typedef struct packed {
    rhc_piece_kind_t kind;
    logic [12:0]     t;
  } rhc_piece_t;

  function automatic logic [15:0] sat_q15(input logic [23:0] v);
    logic [15:0] res;
    if (v > 24'(ONE_Q15)) begin
      res = ONE_Q15;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] wrap_hue(input logic [15:0] v);
    logic [15:0] res;
    if (v >= HUE_360) begin
      res = v - HUE_360;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic rhc_piece_t piece_of(input logic [15:0] hue);
    rhc_piece_t res;
    res.t = '0;
    if (hue < HUE_60) begin
      res.kind = PIECE_RISE;
      res.t    = hue[12:0];
    end else if (hue < HUE_180) begin
      res.kind = PIECE_HIGH;
    end else if (hue < HUE_240) begin
      res.kind = PIECE_FALL;
      res.t    = 13'(HUE_240 - hue);
    end else begin
      res.kind = PIECE_LOW;
    end
    return res;
  endfunction

endpackage

@@ src/rhc_div_pipe.sv @@
module rhc_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] lo_r  [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic [DEN_W-1:0] den_r [QUO_W+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= DEN_W'(num >> QUO_W);
    lo_r[0]  <= num[QUO_W-1:0];
    quo_r[0] <= '0;
    den_r[0] <= den;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] rest;
    logic           ge;

    always_comb begin
      trial = {rem_r[k], lo_r[k][QUO_W-1]};
      ge    = trial >= {1'b0, den_r[k]};
      rest  = trial - {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? rest[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r[k+1]  <= lo_r[k] << 1;
      quo_r[k+1] <= {quo_r[k][QUO_W-2:0], ge};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = quo_r[QUO_W];

endmodule

@@ src/rgb_hls_color_convert.sv @@
// RGB / HLS pixel converter, one pixel per beat.
// Input: a beat is taken on a rising edge with start high and busy low.
//   busy is held low: a new pixel may enter on every cycle.
// Output: out_valid marks a result beat on out_data for one cycle; results
//   leave in input order. The receiver cannot stall the block.
// Throughput: one pixel per clock.
// The depth is set by the two 16-step restoring dividers (saturation and
//   hue) followed by the multiply chains for scaling and for rebuilding RGB.
// Reset (rst_n low at a clock edge) clears all stage valid bits; pixels in
//   flight are dropped and out_valid stays low until new beats arrive.
// Op codes: 0 to HLS, 1 from HLS, 2..4 set hue/sat/lum, 5..7 scale
//   hue/sat/lum by a Q8.8 factor. Alpha is copied through.
module rgb_hls_color_convert
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rhc_in_t  in_data,
  output logic     out_valid,
  output rhc_out_t out_data
);

  localparam int NUM_W   = 32;
  localparam int DEN_W   = 16;
  localparam int QUO_W   = 16;
  localparam int DIV_LAT = QUO_W + 1;

  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  // stage 1: saturate / wrap inputs
  logic        v1_r;
  rhc_op_t     op1_r;
  logic [15:0] alpha1_r, amt1_r, c0_r, c1_r, c2_r;

  always_ff @(posedge clk) begin
    op1_r    <= in_data.op;
    alpha1_r <= in_data.alpha_in;
    amt1_r   <= in_data.amount;
    c0_r     <= (in_data.op == OP_FROM_HLS) ? wrap_hue(in_data.chan_a_in)
                                            : sat_q15(24'(in_data.chan_a_in));
    c1_r     <= sat_q15(24'(in_data.chan_b_in));
    c2_r     <= sat_q15(24'(in_data.chan_c_in));
  end

  // stage 2: max, min, divider operands
  logic [15:0] mx, mn, diff, den, mag;
  logic [16:0] sum, num;
  rhc_base_t   base;
  rhc_side_t   side2_nxt, side2_r;
  logic        v2_r;
  logic [15:0] mag2_r, diff2_r, den2_r;

  always_comb begin
    mx = c0_r;
    mn = c0_r;
    if (c1_r > mx) mx = c1_r;
    if (c2_r > mx) mx = c2_r;
    if (c1_r < mn) mn = c1_r;
    if (c2_r < mn) mn = c2_r;
    diff = mx - mn;
    sum  = 17'(mx) + 17'(mn);
    if (sum <= 17'(ONE_Q15)) begin
      den = sum[15:0];
    end else begin
      den = 16'(17'd65536 - sum);
    end
    if (c0_r == mx) begin
      base = BASE_RED;
      num  = 17'(c1_r) - 17'(c2_r);
    end else if (c1_r == mx) begin
      base = BASE_GREEN;
      num  = 17'(c2_r) - 17'(c0_r);
    end else begin
      base = BASE_BLUE;
      num  = 17'(c0_r) - 17'(c1_r);
    end
    mag = num[16] ? 16'(17'd0 - num) : num[15:0];

    side2_nxt.op    = op1_r;
    side2_nxt.alpha = alpha1_r;
    side2_nxt.amt   = amt1_r;
    side2_nxt.l     = (op1_r == OP_FROM_HLS) ? c1_r : sum[16:1];
    side2_nxt.hin   = c0_r;
    side2_nxt.sin   = c2_r;
    side2_nxt.zero  = (diff == 16'd0);
    side2_nxt.neg   = num[16];
    side2_nxt.base  = base;
  end

  always_ff @(posedge clk) begin
    side2_r <= side2_nxt;
    mag2_r  <= mag;
    diff2_r <= diff;
    den2_r  <= den;
  end

  // dividers
  logic [NUM_W-1:0] hue_num, sat_num;
  logic [QUO_W-1:0] hue_quo, sat_quo;

  assign hue_num = mag2_r * HUE_60;
  assign sat_num = {1'b0, diff2_r, 15'd0};

  rhc_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_hue_div (
    .clk (clk),
    .num (hue_num),
    .den (diff2_r),
    .quo (hue_quo)
  );

  rhc_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_sat_div (
    .clk (clk),
    .num (sat_num),
    .den (den2_r),
    .quo (sat_quo)
  );

  rhc_side_t side_pipe_r [DIV_LAT];
  logic      vd_r        [DIV_LAT];

  always_ff @(posedge clk) begin
    side_pipe_r[0] <= side2_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_pipe_r[i] <= side_pipe_r[i-1];
    end
  end

  // stage 4: resolve hue, apply set ops
  rhc_side_t   sd;
  logic [15:0] hv;
  rhc_hls_t    hls4_nxt, hls4_r;
  logic        v4_r;

  always_comb begin
    sd = side_pipe_r[DIV_LAT-1];
    case (sd.base)
      BASE_RED: begin
        if (sd.neg && hue_quo != 16'd0) begin
          hv = HUE_360 - hue_quo;
        end else begin
          hv = hue_quo;
        end
      end
      BASE_GREEN: hv = sd.neg ? HUE_120 - hue_quo : HUE_120 + hue_quo;
      BASE_BLUE:  hv = sd.neg ? HUE_240 - hue_quo : HUE_240 + hue_quo;
      default:    hv = '0;
    endcase

    hls4_nxt.op    = sd.op;
    hls4_nxt.alpha = sd.alpha;
    hls4_nxt.amt   = sd.amt;
    hls4_nxt.l     = sd.l;
    if (sd.op == OP_FROM_HLS) begin
      hls4_nxt.h = sd.hin;
      hls4_nxt.s = sd.sin;
    end else if (sd.zero) begin
      hls4_nxt.h = '0;
      hls4_nxt.s = '0;
    end else begin
      hls4_nxt.h = hv;
      hls4_nxt.s = sat_quo;
    end
    case (sd.op)
      OP_SET_HUE: hls4_nxt.h = wrap_hue(sd.amt);
      OP_SET_SAT: hls4_nxt.s = sat_q15(24'(sd.amt));
      OP_SET_LUM: hls4_nxt.l = sat_q15(24'(sd.amt));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hls4_r <= hls4_nxt;
  end

  // stage 5: scale product
  logic [15:0] scale_sel;
  logic [31:0] prod5_r;
  rhc_hls_t    hls5_r;
  logic        v5_r;

  always_comb begin
    case (hls4_r.op)
      OP_SCALE_HUE: scale_sel = hls4_r.h;
      OP_SCALE_SAT: scale_sel = hls4_r.s;
      OP_SCALE_LUM: scale_sel = hls4_r.l;
      default:      scale_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod5_r <= scale_sel * hls4_r.amt;
    hls5_r  <= hls4_r;
  end

  // stage 6: quotient by 360 degrees, saturate sat / lum
  logic [23:0] x6_nxt, x6_r;
  logic [28:0] rq;
  logic [15:0] sv;
  rhc_hls_t    hls6_nxt, hls6_r;
  logic [8:0]  qq6_r;
  logic        v6_r;

  always_comb begin
    x6_nxt   = prod5_r[31:8];
    rq       = prod5_r[31:18] * REC45;
    sv       = sat_q15(x6_nxt);
    hls6_nxt = hls5_r;
    case (hls5_r.op)
      OP_SCALE_SAT: hls6_nxt.s = sv;
      OP_SCALE_LUM: hls6_nxt.l = sv;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    x6_r   <= x6_nxt;
    qq6_r  <= rq[28:20];
    hls6_r <= hls6_nxt;
  end

  // stage 7: hue remainder
  rhc_hls_t    hls7_nxt, hls7_r;
  logic [24:0] qh;
  logic        v7_r;

  always_comb begin
    qh       = qq6_r * HUE_360;
    hls7_nxt = hls6_r;
    if (hls6_r.op == OP_SCALE_HUE) begin
      hls7_nxt.h = 16'(x6_r - qh[23:0]);
    end
  end

  always_ff @(posedge clk) begin
    hls7_r <= hls7_nxt;
  end

  // stage 8: lightness products, hue pieces per channel
  logic [15:0] hr, hb;
  logic [16:0] hr_raw;
  logic [31:0] m1_8_r, m2_8_r;
  logic        lo8_r;
  rhc_piece_t  pc_nxt [3];
  rhc_piece_t  pc8_r [3], pc9_r [3], pc10_r [3], pc11_r [3], pc12_r [3];
  rhc_hls_t    t8_r, t9_r, t10_r, t11_r, t12_r;
  logic        v8_r;

  always_comb begin
    hr_raw = 17'(hls7_r.h) + 17'(HUE_120);
    if (hr_raw > 17'(HUE_360)) begin
      hr = 16'(hr_raw - 17'(HUE_360));
    end else begin
      hr = hr_raw[15:0];
    end
    if (hls7_r.h >= HUE_120) begin
      hb = hls7_r.h - HUE_120;
    end else begin
      hb = hls7_r.h + HUE_240;
    end
    pc_nxt[0] = piece_of(hr);
    pc_nxt[1] = piece_of(hls7_r.h);
    pc_nxt[2] = piece_of(hb);
  end

  always_ff @(posedge clk) begin
    m1_8_r <= hls7_r.l * (17'(hls7_r.s) + 17'(ONE_Q15));
    m2_8_r <= hls7_r.l * hls7_r.s;
    lo8_r  <= hls7_r.l <= HALF_Q15;
    pc8_r  <= pc_nxt;
    t8_r   <= hls7_r;
  end

  // stage 9: q2
  logic [16:0] p2raw;
  logic [15:0] p2_9_r;
  logic        v9_r;

  always_comb begin
    if (lo8_r) begin
      p2raw = m1_8_r[31:15];
    end else begin
      p2raw = 17'(t8_r.l) + 17'(t8_r.s) - m2_8_r[31:15];
    end
  end

  always_ff @(posedge clk) begin
    p2_9_r <= sat_q15(24'(p2raw));
    pc9_r  <= pc8_r;
    t9_r   <= t8_r;
  end

  // stage 10: q1 and span
  logic [16:0] twol;
  logic [15:0] p1;
  logic [15:0] p1_10_r, p2_10_r, d10_r;
  logic        v10_r;

  always_comb begin
    twol = {t9_r.l, 1'b0};
    if (twol > 17'(p2_9_r)) begin
      p1 = sat_q15(24'(twol - 17'(p2_9_r)));
    end else begin
      p1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    p1_10_r <= p1;
    p2_10_r <= p2_9_r;
    d10_r   <= p2_9_r - p1;
    pc10_r  <= pc9_r;
    t10_r   <= t9_r;
  end

  // stage 11: span times offset
  logic [28:0] dt11_r [3];
  logic [15:0] p1_11_r, p2_11_r;
  logic        v11_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dt11_r[k] <= d10_r * pc10_r[k].t;
    end
    p1_11_r <= p1_10_r;
    p2_11_r <= p2_10_r;
    pc11_r  <= pc10_r;
    t11_r   <= t10_r;
  end

  // stage 12: divide by 60 degrees
  logic [39:0] rd [3];
  logic [15:0] qd12_r [3];
  logic [15:0] p1_12_r, p2_12_r;
  logic        v12_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd[k] = dt11_r[k][28:9] * REC15;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      qd12_r[k] <= rd[k][38:23];
    end
    p1_12_r <= p1_11_r;
    p2_12_r <= p2_11_r;
    pc12_r  <= pc11_r;
    t12_r   <= t11_r;
  end

  // stage 13: pick channel values
  logic [15:0] ch [3];
  rhc_out_t    out_nxt, out_r;
  logic        v13_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (pc12_r[k].kind)
        PIECE_RISE, PIECE_FALL: ch[k] = sat_q15(24'(p1_12_r) + 24'(qd12_r[k]));
        PIECE_HIGH:             ch[k] = p2_12_r;
        PIECE_LOW:              ch[k] = p1_12_r;
        default:                ch[k] = p1_12_r;
      endcase
    end
    out_nxt.alpha_out = t12_r.alpha;
    if (t12_r.op == OP_TO_HLS) begin
      out_nxt.chan_a_out = t12_r.h;
      out_nxt.chan_b_out = t12_r.l;
      out_nxt.chan_c_out = t12_r.s;
    end else if (t12_r.s == 16'd0) begin
      out_nxt.chan_a_out = t12_r.l;
      out_nxt.chan_b_out = t12_r.l;
      out_nxt.chan_c_out = t12_r.l;
    end else begin
      out_nxt.chan_a_out = ch[0];
      out_nxt.chan_b_out = ch[1];
      out_nxt.chan_c_out = ch[2];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_r[i] <= 1'b0;
      end
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else begin
      v1_r    <= in_acc;
      v2_r    <= v1_r;
      vd_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      v4_r  <= vd_r[DIV_LAT-1];
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
    end
  end

  assign out_valid = v13_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_chan_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.chan_a_out < HUE_360)
    else $error("chan_a_out out of range");

  a_chan_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.chan_b_out <= ONE_Q15)
    else $error("chan_b_out above 1.0");

  a_chan_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.chan_c_out <= ONE_Q15)
    else $error("chan_c_out above 1.0");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> p1_10_r <= p2_10_r)
    else $error("q1 above q2");
`endif

endmodule
